/* design/zrss_pkg.sv */
// Shared types and codes for the zero-run symbol statistics block.
// Used by zrss_front and zero_run_symbol_statistics.
// No dependencies.
`timescale 1ns / 1ps

package zrss_pkg;

	// request kinds on the input stream
	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_FLUSH = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;
	localparam logic [1:0] REQ_CLEAR = 2'd3;

	// store selector of a read request
	localparam logic [1:0] SEL_BASIC  = 2'd0;
	localparam logic [1:0] SEL_BEFORE = 2'd1;
	localparam logic [1:0] SEL_AFTER  = 2'd2;

	// store that feeds count_value in the result
	localparam logic [1:0] SRC_NONE   = 2'd0;
	localparam logic [1:0] SRC_BASIC  = 2'd1;
	localparam logic [1:0] SRC_BEFORE = 2'd2;
	localparam logic [1:0] SRC_AFTER  = 2'd3;

	// configuration register indexes
	localparam logic REG_ALPHABET_SIZE  = 1'b0;
	localparam logic REG_RUN_CODE_COUNT = 1'b1;

	// fixed field widths
	localparam int SYM_FIELD_W = 8;
	localparam int IDX_FIELD_W = 9;
	localparam int LEN_W       = 24;
	localparam int CODE_W      = 9;
	localparam int CFG_W       = 9;
	localparam int ALPHA_CFG_W = 9;
	localparam int RUNS_CFG_W  = 8;

	// stream packing
	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = 5;
	localparam int M_TDATA_W = 64;
	localparam int M_TUSER_W = 4;

	// decoded operation handed from the front end to the update stage
	typedef struct packed {
		logic       bump_basic;
		logic       bump_before;
		logic       bump_after;
		logic [1:0] rd_src;
		logic       run_done;
		logic       code_valid;
		logic       after_valid;
		logic       run_sat;
		logic       clear;
	} zrss_op_t;

endpackage

/* design/zrss_count_bank.sv */
// One count store: synchronous memory with read-modify-write of a
// saturating counter, one-deep write forwarding and a clear write port.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module zrss_count_bank #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int CW    = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          bump,
	input  logic          adv,
	input  logic          clr_we,
	input  logic [AW-1:0] clr_addr,
	output logic [CW-1:0] old_val,
	output logic          hit_full
);

	localparam logic [CW-1:0] FULL = '1;

	logic [CW-1:0] mem [DEPTH];
	logic [CW-1:0] rdata_q;
	logic [AW-1:0] addr_s1;
	logic          bump_s1;
	logic          fwd_en_q;
	logic [AW-1:0] fwd_addr_q;
	logic [CW-1:0] fwd_data_q;
	logic [CW-1:0] inc_val;

	// request held in the update stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_s1 <= '0;
			bump_s1 <= 1'b0;
		end else if (rd_en) begin
			addr_s1 <= rd_addr;
			bump_s1 <= bump;
		end else if (adv) begin
			bump_s1 <= 1'b0;
		end
	end

	// storage: clear sweep wins, otherwise write back the bumped count
	always_ff @(posedge clk) begin
		if (clr_we) begin
			mem[clr_addr] <= '0;
		end else if (adv && bump_s1) begin
			mem[addr_s1] <= inc_val;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// remember the write that landed on the same edge as the next read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_en_q   <= 1'b0;
			fwd_addr_q <= '0;
			fwd_data_q <= '0;
		end else if (clr_we) begin
			fwd_en_q <= 1'b0;
		end else if (adv || rd_en) begin
			fwd_en_q   <= adv && bump_s1;
			fwd_addr_q <= addr_s1;
			fwd_data_q <= inc_val;
		end
	end

	// forwarded old value and saturating increment
	always_comb begin
		old_val  = (fwd_en_q && fwd_addr_q == addr_s1) ? fwd_data_q : rdata_q;
		inc_val  = (old_val == FULL) ? old_val : old_val + CW'(1);
		hit_full = bump_s1 && (inc_val == FULL);
	end

endmodule

/* design/zrss_front.sv */
// Request decode: configuration registers, zero-run counter, run code
// mapping and store addresses for the read-modify-write stage.
// Depends on zrss_pkg.
`timescale 1ns / 1ps

module zrss_front #(
	parameter int MAX_SYMBOLS   = 256,
	parameter int MAX_RUN_CODES = 128,
	parameter int COUNT_BITS    = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               accept,
	input  logic [1:0]                         req_type,
	input  logic [zrss_pkg::SYM_FIELD_W-1:0]   symbol,
	input  logic                               zero_mark,
	input  logic [1:0]                         store_select,
	input  logic [zrss_pkg::IDX_FIELD_W-1:0]   read_index,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [zrss_pkg::CFG_W-1:0]         cfg_data,
	output zrss_pkg::zrss_op_t                 op,
	output logic [$clog2(MAX_SYMBOLS)-1:0]     basic_addr,
	output logic [$clog2(MAX_SYMBOLS + MAX_RUN_CODES)-1:0] before_addr,
	output logic [$clog2(MAX_SYMBOLS)-1:0]     after_addr,
	output logic [zrss_pkg::LEN_W-1:0]         run_length,
	output logic [zrss_pkg::CODE_W-1:0]        run_code
);

	localparam int SYM_W    = $clog2(MAX_SYMBOLS);
	localparam int BZ_DEPTH = MAX_SYMBOLS + MAX_RUN_CODES;
	localparam int BZ_W     = $clog2(BZ_DEPTH);
	localparam int AL_W     = $clog2(MAX_SYMBOLS + 1);
	localparam int RC_W     = $clog2(MAX_RUN_CODES + 1);
	localparam int IW       = (BZ_W >= 9) ? BZ_W + 1 : 10;
	localparam int RW       = (COUNT_BITS > RC_W) ? COUNT_BITS : RC_W;
	localparam int AFW      = (AL_W > zrss_pkg::ALPHA_CFG_W) ? AL_W : zrss_pkg::ALPHA_CFG_W;
	localparam int RFW      = (RC_W > zrss_pkg::RUNS_CFG_W) ? RC_W : zrss_pkg::RUNS_CFG_W;
	localparam int ALPHA_RST = (MAX_SYMBOLS < 256) ? MAX_SYMBOLS : 256;
	localparam int RUNS_RST  = (MAX_RUN_CODES < 128) ? MAX_RUN_CODES : 128;
	localparam logic [COUNT_BITS-1:0] FULL = '1;

	logic [AL_W-1:0]       alpha_q;
	logic [RC_W-1:0]       runs_q;
	logic [COUNT_BITS-1:0] run_q;
	logic [COUNT_BITS-1:0] run_d;
	logic [COUNT_BITS-1:0] run_inc;
	logic [AFW-1:0]        alpha_raw;
	logic [RFW-1:0]        runs_raw;
	logic [IW-1:0]         sym_w;
	logic [IW-1:0]         idx_w;
	logic [IW-1:0]         code_w;
	logic [RC_W-1:0]       run_clip;
	logic                  sym_ok;
	logic                  run_open;
	logic                  use_code;

	// configuration, clamped to the supported range on write
	always_comb begin
		alpha_raw = AFW'(cfg_data[zrss_pkg::ALPHA_CFG_W-1:0]);
		runs_raw  = RFW'(cfg_data[zrss_pkg::RUNS_CFG_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= AL_W'(ALPHA_RST);
			runs_q  <= RC_W'(RUNS_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				zrss_pkg::REG_ALPHABET_SIZE: begin
					if (alpha_raw == '0)
						alpha_q <= AL_W'(1);
					else if (alpha_raw > AFW'(MAX_SYMBOLS))
						alpha_q <= AL_W'(MAX_SYMBOLS);
					else
						alpha_q <= AL_W'(alpha_raw);
				end
				zrss_pkg::REG_RUN_CODE_COUNT: begin
					if (runs_raw == '0)
						runs_q <= RC_W'(1);
					else if (runs_raw > RFW'(MAX_RUN_CODES))
						runs_q <= RC_W'(MAX_RUN_CODES);
					else
						runs_q <= RC_W'(runs_raw);
				end
				default: ;
			endcase
		end
	end

	// run code of the open run, clamped to the tail code
	always_comb begin
		run_clip = (RW'(run_q) >= RW'(runs_q)) ? runs_q : RC_W'(run_q);
		code_w   = IW'(alpha_q) + IW'(run_clip) - IW'(1);
		run_inc  = (run_q == FULL) ? run_q : run_q + COUNT_BITS'(1);
		run_open = (run_q != '0);
		sym_w    = zero_mark ? '0 : IW'(symbol);
		idx_w    = IW'(read_index);
		sym_ok   = sym_w < IW'(alpha_q);
	end

	// decode of one request
	always_comb begin
		op         = '0;
		run_d      = run_q;
		use_code   = 1'b0;
		run_length = '0;
		run_code   = '0;
		unique case (req_type)
			zrss_pkg::REQ_ADD: begin
				if (sym_ok) begin
					op.bump_basic = 1'b1;
					if (sym_w == '0) begin
						run_d      = run_inc;
						op.run_sat = (run_inc == FULL);
					end else if (run_open) begin
						op.bump_before = 1'b1;
						op.bump_after  = 1'b1;
						op.run_done    = 1'b1;
						op.code_valid  = 1'b1;
						op.after_valid = 1'b1;
						use_code       = 1'b1;
						run_length     = zrss_pkg::LEN_W'(run_q);
						run_code       = zrss_pkg::CODE_W'(code_w);
						run_d          = '0;
					end else begin
						op.bump_before = 1'b1;
						op.code_valid  = 1'b1;
						run_code       = zrss_pkg::CODE_W'(sym_w);
					end
				end
			end
			zrss_pkg::REQ_FLUSH: begin
				if (run_open) begin
					op.bump_before = 1'b1;
					op.run_done    = 1'b1;
					op.code_valid  = 1'b1;
					use_code       = 1'b1;
					run_length     = zrss_pkg::LEN_W'(run_q);
					run_code       = zrss_pkg::CODE_W'(code_w);
					run_d          = '0;
				end
			end
			zrss_pkg::REQ_READ: begin
				unique case (store_select)
					zrss_pkg::SEL_BASIC:
						op.rd_src = (idx_w < IW'(MAX_SYMBOLS)) ?
							zrss_pkg::SRC_BASIC : zrss_pkg::SRC_NONE;
					zrss_pkg::SEL_BEFORE:
						op.rd_src = (idx_w < IW'(BZ_DEPTH)) ?
							zrss_pkg::SRC_BEFORE : zrss_pkg::SRC_NONE;
					zrss_pkg::SEL_AFTER:
						op.rd_src = (idx_w < IW'(MAX_SYMBOLS)) ?
							zrss_pkg::SRC_AFTER : zrss_pkg::SRC_NONE;
					default:
						op.rd_src = zrss_pkg::SRC_NONE;
				endcase
			end
			zrss_pkg::REQ_CLEAR: begin
				op.clear = 1'b1;
				run_d    = '0;
			end
			default: ;
		endcase
	end

	// store addresses: read index for reads, symbol or run code otherwise
	always_comb begin
		if (req_type == zrss_pkg::REQ_READ) begin
			basic_addr  = idx_w[SYM_W-1:0];
			after_addr  = idx_w[SYM_W-1:0];
			before_addr = idx_w[BZ_W-1:0];
		end else begin
			basic_addr  = sym_w[SYM_W-1:0];
			after_addr  = sym_w[SYM_W-1:0];
			before_addr = use_code ? code_w[BZ_W-1:0] : sym_w[BZ_W-1:0];
		end
	end

	// zero-run counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (accept) begin
			run_q <= run_d;
		end
	end

endmodule

/* design/zero_run_symbol_statistics.sv */
// Top level: zero-run tokenizer with three saturating count stores.
// Depends on zrss_pkg, zrss_front, zrss_count_bank.
//
//  port group  | dir | fields (low bit first)
//  ------------+-----+---------------------------------------------------------
//  s_*         | in  | tdata: symbol, read_index; tuser: req_type, zero_mark,
//              |     |        store_select
//  m_*         | out | tdata: run_length, run_code, count_value;
//              |     | tuser: run_done, run_code_valid, after_zero_valid, saturated
//  cfg_*       | in  | index 0 alphabet_size, index 1 run_code_count
//
// One request per cycle while s_tready is high; a result passes the memory read
// into the update stage, then increment and write-back into the output register.
// Back-to-back bumps of one count bin are forwarded from the last write.
// After reset and after a clear request the stores are swept to zero, with
// s_tready low. A stall on m_tready holds the update stage; s_tready is low
// while a held request waits there.
`timescale 1ns / 1ps

module zero_run_symbol_statistics #(
	parameter int MAX_SYMBOLS   = 256,
	parameter int MAX_RUN_CODES = 128,
	parameter int COUNT_BITS    = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [zrss_pkg::S_TDATA_W-1:0]    s_tdata,  // symbol, read_index, pad
	input  logic [zrss_pkg::S_TUSER_W-1:0]    s_tuser,  // req_type, zero_mark, store_select
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [zrss_pkg::M_TDATA_W-1:0]    m_tdata,  // run_length, run_code, count_value, pad
	output logic [zrss_pkg::M_TUSER_W-1:0]    m_tuser,  // run_done, run_code_valid,
	                                                    // after_zero_valid, saturated
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [zrss_pkg::CFG_W-1:0]        cfg_data
);

	localparam int SYM_W    = $clog2(MAX_SYMBOLS);
	localparam int BZ_DEPTH = MAX_SYMBOLS + MAX_RUN_CODES;
	localparam int BZ_W     = $clog2(BZ_DEPTH);
	localparam int PAD_W    = zrss_pkg::M_TDATA_W - 2 * zrss_pkg::LEN_W - zrss_pkg::CODE_W;
	localparam logic [COUNT_BITS-1:0] FULL = '1;

	zrss_pkg::zrss_op_t             op_s0;
	zrss_pkg::zrss_op_t             op_s1;
	logic                           s1_v;
	logic                           s1_adv;
	logic                           accept;
	logic [SYM_W-1:0]               basic_addr;
	logic [BZ_W-1:0]                before_addr;
	logic [SYM_W-1:0]               after_addr;
	logic [zrss_pkg::LEN_W-1:0]     run_length_s0;
	logic [zrss_pkg::CODE_W-1:0]    run_code_s0;
	logic [zrss_pkg::LEN_W-1:0]     run_length_s1;
	logic [zrss_pkg::CODE_W-1:0]    run_code_s1;
	logic [COUNT_BITS-1:0]          basic_old;
	logic [COUNT_BITS-1:0]          before_old;
	logic [COUNT_BITS-1:0]          after_old;
	logic                           basic_full;
	logic                           before_full;
	logic                           after_full;
	logic [COUNT_BITS-1:0]          rd_val;
	logic                           sat_s1;
	logic                           sweep_q;
	logic [BZ_W-1:0]                sweep_cnt_q;
	logic                           sweep_sym;
	logic                           out_v_q;
	logic [zrss_pkg::LEN_W-1:0]     out_len_q;
	logic [zrss_pkg::CODE_W-1:0]    out_code_q;
	logic [zrss_pkg::LEN_W-1:0]     out_count_q;
	logic [zrss_pkg::M_TUSER_W-1:0] out_flags_q;

	// handshake
	always_comb begin
		s1_adv   = s1_v && (!out_v_q || m_tready);
		s_tready = !sweep_q && !(s1_v && op_s1.clear) && (!s1_v || s1_adv);
		accept   = s_tvalid && s_tready;
	end

	zrss_front #(
		.MAX_SYMBOLS   (MAX_SYMBOLS),
		.MAX_RUN_CODES (MAX_RUN_CODES),
		.COUNT_BITS    (COUNT_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.req_type     (s_tuser[1:0]),
		.symbol       (s_tdata[7:0]),
		.zero_mark    (s_tuser[2]),
		.store_select (s_tuser[4:3]),
		.read_index   (s_tdata[16:8]),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.op           (op_s0),
		.basic_addr   (basic_addr),
		.before_addr  (before_addr),
		.after_addr   (after_addr),
		.run_length   (run_length_s0),
		.run_code     (run_code_s0)
	);

	// clear sweep over all three stores
	always_comb begin
		sweep_sym = sweep_q && (sweep_cnt_q < BZ_W'(MAX_SYMBOLS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= 1'b1;
			sweep_cnt_q <= '0;
		end else if (sweep_q) begin
			if (sweep_cnt_q == BZ_W'(BZ_DEPTH - 1)) begin
				sweep_q <= 1'b0;
			end
			sweep_cnt_q <= sweep_cnt_q + BZ_W'(1);
		end else if (s1_adv && op_s1.clear) begin
			sweep_q     <= 1'b1;
			sweep_cnt_q <= '0;
		end
	end

	zrss_count_bank #(.DEPTH(MAX_SYMBOLS), .AW(SYM_W), .CW(COUNT_BITS)) u_basic (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (basic_addr),
		.bump     (op_s0.bump_basic),
		.adv      (s1_adv),
		.clr_we   (sweep_sym),
		.clr_addr (sweep_cnt_q[SYM_W-1:0]),
		.old_val  (basic_old),
		.hit_full (basic_full)
	);

	zrss_count_bank #(.DEPTH(BZ_DEPTH), .AW(BZ_W), .CW(COUNT_BITS)) u_before (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (before_addr),
		.bump     (op_s0.bump_before),
		.adv      (s1_adv),
		.clr_we   (sweep_q),
		.clr_addr (sweep_cnt_q),
		.old_val  (before_old),
		.hit_full (before_full)
	);

	zrss_count_bank #(.DEPTH(MAX_SYMBOLS), .AW(SYM_W), .CW(COUNT_BITS)) u_after (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (after_addr),
		.bump     (op_s0.bump_after),
		.adv      (s1_adv),
		.clr_we   (sweep_sym),
		.clr_addr (sweep_cnt_q[SYM_W-1:0]),
		.old_val  (after_old),
		.hit_full (after_full)
	);

	// update stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v  <= 1'b0;
			op_s1 <= '0;
		end else if (accept) begin
			s1_v  <= 1'b1;
			op_s1 <= op_s0;
		end else if (s1_adv) begin
			s1_v <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			run_length_s1 <= run_length_s0;
			run_code_s1   <= run_code_s0;
		end
	end

	// read value and saturation flag
	always_comb begin
		unique case (op_s1.rd_src)
			zrss_pkg::SRC_BASIC:  rd_val = basic_old;
			zrss_pkg::SRC_BEFORE: rd_val = before_old;
			zrss_pkg::SRC_AFTER:  rd_val = after_old;
			default:              rd_val = '0;
		endcase
		sat_s1 = op_s1.run_sat || basic_full || before_full || after_full ||
			(op_s1.rd_src != zrss_pkg::SRC_NONE && rd_val == FULL);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_adv) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_len_q   <= run_length_s1;
			out_code_q  <= run_code_s1;
			out_count_q <= zrss_pkg::LEN_W'(rd_val);
			out_flags_q <= {sat_s1, op_s1.after_valid, op_s1.code_valid, op_s1.run_done};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_count_q, out_code_q, out_len_q};
	assign m_tuser  = out_flags_q;

	// no request is taken while the stores are being cleared
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_q |-> !s_tready)
		else $error("request accepted during clear sweep");

	// a clear leaving the update stage starts the sweep
	a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && op_s1.clear) |=> (sweep_q && sweep_cnt_q == '0))
		else $error("clear did not start the sweep");

	// an after-zero count only comes with a finished run and its code
	a_after_implies_run: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2]) |-> (m_tuser[0] && m_tuser[1]))
		else $error("after-zero count without finished run");

	// reads never bump a store
	a_read_no_bump: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v && op_s1.rd_src != zrss_pkg::SRC_NONE) |->
		!(op_s1.bump_basic || op_s1.bump_before || op_s1.bump_after))
		else $error("read request bumps a count");

endmodule
